### hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

### hw/rtl/mec_pkg.sv
package mec_pkg;

	localparam int DEFAULT_WIDTH = 16;

	localparam int RESET_EXPONENT = 11;
	localparam int RESET_MODULUS = 899;

	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_EXPONENT = 1'b0;
	localparam cfg_idx_t REG_MODULUS = 1'b1;

endpackage

### hw/rtl/modular_exponentiation_cipher.sv
// Modular exponentiation: each input transaction carries a base value; the block
// returns value ** exponent mod modulus (1 when exponent is zero; modulus 0 acts
// as 2**WIDTH).
// Channels: s_* takes the base, m_* delivers the result, cfg_* writes the
// exponent (index 0) and modulus (index 1). cfg_ready is always high; write
// registers only while no transaction is in flight.
// Steps: the base is first reduced mod the modulus; then each exponent bit up to
// the highest set one takes a multiply into the accumulator when the bit is set,
// then a square (no square after the highest set bit); last the output register
// is loaded, and m_tvalid and s_tready rise together as the block goes idle.
// Each reduction, square and multiply runs on one bit-serial modular multiplier
// that does one shift, add and conditional subtract per cycle and is shared by
// all squares and multiplies.
// One item is in work at a time; s_tready is high only while idle. A finished
// result sits in the output register, and the next item may be accepted while it
// waits; if that next item finishes before the result is taken, it holds until
// m_tready frees the register.
// Reset restores exponent 11 and modulus 899 and empties the block.
module modular_exponentiation_cipher #(
	parameter int WIDTH = mec_pkg::DEFAULT_WIDTH,
	localparam int TDATA_W = ((WIDTH + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [TDATA_W-1:0]       s_tdata,   // [WIDTH-1:0] value, rest zero
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [TDATA_W-1:0]       m_tdata,   // [WIDTH-1:0] result, rest zero
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [mec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [WIDTH-1:0]         cfg_data
);
	import mec_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_BASE   = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_SQR    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t              state_q;
	logic [WIDTH-1:0]    exponent_q;
	logic [WIDTH-1:0]    modulus_q;
	logic [WIDTH-1:0]    exp_q;
	logic [WIDTH:0]      mod_q;
	logic [WIDTH-1:0]    acc_q;
	logic [WIDTH-1:0]    sq_q;
	logic [WIDTH-1:0]    mul_q;
	logic [WIDTH-1:0]    r_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                m_tvalid_q;
	logic [WIDTH-1:0]    m_data_q;

	logic [WIDTH-1:0]    a_sel;
	logic [WIDTH+1:0]    t_sum;
	logic [WIDTH+1:0]    m1_ext;
	logic [WIDTH+1:0]    m2_ext;
	logic [WIDTH-1:0]    r_next;
	logic                op_last;
	logic                in_acc;
	logic [WIDTH-1:0]    exp_shr;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = TDATA_W'(m_data_q);
	assign in_acc    = s_tvalid && s_tready;
	assign exp_shr   = exp_q >> 1;

	// Shared unit: r <- (2r + bit*a) mod m, with r < m and a <= m so the sum stays below 3m
	assign a_sel  = (state_q == ST_BASE) ? WIDTH'(1) : sq_q;
	assign t_sum  = {1'b0, r_q, 1'b0} + (mul_q[WIDTH-1] ? (WIDTH+2)'(a_sel) : '0);
	assign m1_ext = {1'b0, mod_q};
	assign m2_ext = {mod_q, 1'b0};

	always_comb begin
		if (t_sum >= m2_ext) begin
			r_next = WIDTH'(t_sum - m2_ext);
		end else if (t_sum >= m1_ext) begin
			r_next = WIDTH'(t_sum - m1_ext);
		end else begin
			r_next = WIDTH'(t_sum);
		end
	end

	assign op_last = (cnt_q == CNT_W'(WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= WIDTH'(RESET_EXPONENT);
			modulus_q  <= WIDTH'(RESET_MODULUS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data;
				REG_MODULUS:  modulus_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (state_q == ST_FINISH && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= ST_BASE;
					end
				end
				ST_BASE, ST_MUL, ST_SQR: begin
					if (op_last) begin
						cnt_q <= '0;
						if (state_q == ST_BASE) begin
							if (exp_q == '0) begin
								state_q <= ST_FINISH;
							end else if (exp_q[0]) begin
								state_q <= ST_MUL;
							end else begin
								state_q <= ST_SQR;
							end
						end else if (state_q == ST_MUL) begin
							state_q <= (exp_shr == '0) ? ST_FINISH : ST_SQR;
						end else begin
							state_q <= exp_shr[0] ? ST_MUL : ST_SQR;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mul_q <= s_tdata[WIDTH-1:0];
					exp_q <= exponent_q;
					mod_q <= {(modulus_q == '0), modulus_q};
					r_q   <= '0;
				end
			end
			ST_BASE, ST_MUL, ST_SQR: begin
				if (op_last) begin
					r_q <= '0;
					if (state_q == ST_BASE) begin
						sq_q  <= r_next;
						acc_q <= WIDTH'(1);
						mul_q <= exp_q[0] ? WIDTH'(1) : r_next;
					end else if (state_q == ST_MUL) begin
						acc_q <= r_next;
						mul_q <= sq_q;
					end else begin
						sq_q  <= r_next;
						exp_q <= exp_shr;
						mul_q <= exp_shr[0] ? acc_q : r_next;
					end
				end else begin
					mul_q <= mul_q << 1;
					r_q   <= r_next;
				end
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					m_data_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

endmodule

### hw/rtl/mec_checker.sv
`include "assert_macros.svh"

module mec_checker #(
	parameter int WIDTH = mec_pkg::DEFAULT_WIDTH,
	localparam int TDATA_W = ((WIDTH + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata
);
	import mec_pkg::*;

	// A stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Accepting an item makes the block busy
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A new result only appears after the block was busy computing it
	`ASSERT_SAME(a_result_from_work, clk, arst_n, $rose(m_tvalid), !$past(s_tready))

endmodule

bind modular_exponentiation_cipher mec_checker #(.WIDTH(WIDTH)) u_mec_checker (.*);

### verif/tb_modular_exponentiation_cipher.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation_cipher;
	import mec_pkg::*;

	localparam int W = DEFAULT_WIDTH;
	// Cycle limit covers the slowest items, with gaps and stalls,
	// for around 1000 items, taken several times over.
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RX_HOLD = 2500;
	localparam int DRAIN_CYCLES = 600;
	localparam int RANDOM_ITEMS = 850;
	localparam int TAIL_ITEMS = 150;
	localparam int NDIR = 24;

	typedef logic [W-1:0] word_t;

	typedef struct packed {
		logic  reload;   // write exponent and modulus before this row
		word_t expo;
		word_t modv;
		word_t value;
		logic  known;    // result typed in below, else computed
		word_t result;
	} vec_t;

	localparam vec_t DIRECTED [NDIR] = '{
		// registers as left by reset: exponent 11, modulus 899
		'{1'b0, 16'd0,     16'd0,     16'd0,     1'b1, 16'd0},
		'{1'b0, 16'd0,     16'd0,     16'd1,     1'b1, 16'd1},
		'{1'b0, 16'd0,     16'd0,     16'd899,   1'b1, 16'd0},
		'{1'b0, 16'd0,     16'd0,     16'hFFFF,  1'b0, 16'd0},
		'{1'b0, 16'd0,     16'd0,     16'd2,     1'b1, 16'd250},
		// zero exponent gives 1 even with modulus 1
		'{1'b1, 16'd0,     16'd1,     16'd0,     1'b1, 16'd1},
		'{1'b0, 16'd0,     16'd1,     16'hFFFF,  1'b1, 16'd1},
		// modulus 1 with a nonzero exponent gives 0
		'{1'b1, 16'd9,     16'd1,     16'd77,    1'b1, 16'd0},
		// zero to the zero is 1, zero modulus wraps at the word width
		'{1'b1, 16'd0,     16'd0,     16'd0,     1'b1, 16'd1},
		'{1'b1, 16'hFFFF,  16'd0,     16'hFFFF,  1'b1, 16'hFFFF},
		'{1'b0, 16'hFFFF,  16'd0,     16'd2,     1'b1, 16'd0},
		'{1'b0, 16'hFFFF,  16'd0,     16'd3,     1'b0, 16'd0},
		'{1'b1, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 16'd0},
		'{1'b0, 16'hFFFF,  16'hFFFF,  16'hFFFE,  1'b0, 16'd0},
		'{1'b0, 16'hFFFF,  16'hFFFF,  16'hAAAA,  1'b0, 16'd0},
		'{1'b0, 16'hFFFF,  16'hFFFF,  16'h5555,  1'b0, 16'd0},
		'{1'b1, 16'd1,     16'hFFFF,  16'd1234,  1'b1, 16'd1234},
		'{1'b0, 16'd1,     16'hFFFF,  16'hFFFF,  1'b1, 16'd0},
		'{1'b1, 16'd2,     16'd65521, 16'd40000, 1'b0, 16'd0},
		// private key 611 undoes public key 11 for n = 29 * 31
		'{1'b1, 16'd611,   16'd899,   16'd250,   1'b1, 16'd2},
		'{1'b0, 16'd611,   16'd899,   16'd0,     1'b1, 16'd0},
		'{1'b1, 16'd32768, 16'd12345, 16'd7,     1'b0, 16'd0},
		'{1'b1, 16'h5555,  16'hAAAA,  16'hFFFF,  1'b0, 16'd0},
		'{1'b0, 16'h5555,  16'hAAAA,  16'd0,     1'b1, 16'd0}
	};

	logic     clk;
	logic     arst_n;
	logic     s_tvalid;
	logic     s_tready;
	word_t    s_tdata;   // [15:0] value
	logic     m_tvalid;
	logic     m_tready;
	word_t    m_tdata;   // [15:0] result
	logic     cfg_valid;
	logic     cfg_ready;
	cfg_idx_t cfg_index;
	word_t    cfg_data;

	word_t cur_exponent = word_t'(RESET_EXPONENT);
	word_t cur_modulus = word_t'(RESET_MODULUS);
	word_t pending_results [$];
	word_t staged_result;
	int    mismatches = 0;
	int    sent = 0;
	int    gap_odds = 6;
	bit    rx_hold_req = 1'b0;
	int    cycle_count = 0;

	modular_exponentiation_cipher #(.WIDTH(W)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// modulus 0 stands for 2**W
	function automatic word_t fold(input logic [63:0] x, input word_t m);
		if (m == '0)
			return x[W-1:0];
		return word_t'(x % m);
	endfunction

	// right-to-left square and multiply
	function automatic word_t modexp(input word_t base, input word_t expo, input word_t m);
		word_t acc;
		word_t sq;
		acc = word_t'(1);
		sq = fold(64'(base), m);
		for (int i = 0; i < W; i++) begin
			if (expo[i])
				acc = fold(64'(acc) * 64'(sq), m);
			sq = fold(64'(sq) * 64'(sq), m);
		end
		return acc;
	endfunction

	function automatic word_t pick_exponent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return word_t'(1);
			3, 4, 5: return word_t'($urandom_range(2, 255));
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic word_t pick_modulus();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return word_t'(1);
			2: return '1;
			3, 4, 5: return word_t'($urandom_range(2, 1023));
			default: return word_t'($urandom_range(2, 65535));
		endcase
	endfunction

	function automatic word_t pick_value(input word_t modv);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return word_t'(1);
			2: return '1;
			3: return modv - word_t'(1);
			4: return modv;
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input word_t got, input word_t want);
		mismatches++;
		$display("mismatch @%0t: %s, got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic offer(input word_t value, input logic known, input word_t result);
		int n;
		@(negedge clk);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			n = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		staged_result <= known ? result : modexp(value, cur_exponent, cur_modulus);
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// stop offering and wait until every result is back
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input word_t expo, input word_t modv);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_EXPONENT;
		cfg_data <= expo;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_MODULUS;
		cfg_data <= modv;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EXPONENT: cur_exponent = cfg_data;
					REG_MODULUS: cur_modulus = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				pending_results = {pending_results, staged_result};
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("unexpected result", m_tdata, '0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want)
						flag_mismatch("result", m_tdata, want);
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD) @(negedge clk);
			end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		word_t expo;
		word_t modv;
		int    n;
		int    phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		staged_result = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_EXPONENT;
		cfg_data = '0;
		phase = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NDIR; i++) begin
			if (DIRECTED[i].reload)
				configure(DIRECTED[i].expo, DIRECTED[i].modv);
			offer(DIRECTED[i].value, DIRECTED[i].known, DIRECTED[i].result);
		end

		while (sent < NDIR + RANDOM_ITEMS) begin
			expo = pick_exponent();
			modv = pick_modulus();
			configure(expo, modv);
			case ($urandom_range(0, 2))
				0: gap_odds = 0;
				1: gap_odds = 3;
				default: gap_odds = 12;
			endcase
			n = $urandom_range(10, 60);
			// first phase: receiver holds off long enough for the input to back up
			if (phase == 0)
				rx_hold_req = 1'b1;
			for (int k = 0; k < n; k++) begin
				if (phase == 1 && k == n / 2)
					settle();
				offer(pick_value(modv), 1'b0, '0);
			end
			phase++;
		end

		gap_odds = 0;
		for (int t = 0; t < TAIL_ITEMS; t++) begin
			if (t % 50 == 0) begin
				expo = pick_exponent();
				modv = pick_modulus();
				configure(expo, modv);
			end
			offer(pick_value(modv), 1'b0, '0);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mec_pkg.sv
hw/rtl/modular_exponentiation_cipher.sv
hw/rtl/mec_checker.sv
verif/tb_modular_exponentiation_cipher.sv
